FILE: design/vad_pkg.sv
// Package for the vector angle block: shared types, constants and tables.
`timescale 1ns / 1ps
`default_nettype none
package vad_pkg;

  // Result case codes.
  typedef enum logic [1:0] {
    CASE_GENERAL  = 2'd0,
    CASE_SAME     = 2'd1,
    CASE_OPPOSITE = 2'd2,
    CASE_RIGHT    = 2'd3
  } case_code_t;

  // Configuration register indexes.
  localparam logic [0:0] REG_MATCH_TOL  = 1'b0;
  localparam logic [0:0] REG_RIGHT_BAND = 1'b1;

  localparam int COS_ONE      = 32768;
  localparam int COS_CLAMP    = 32440;
  localparam int DEG180_Q16   = 11796480;
  localparam int DEG180_Q8    = 46080;
  localparam int DEG90_Q8     = 23040;
  localparam int CORDIC_PREC  = 14;

  // atan(2^-i) in degrees, Q16.
  function automatic logic [21:0] atan_deg(input int i);
    logic [21:0] t;
    begin
      case (i)
        0: t = 22'd2949120;  1: t = 22'd1740967;  2: t = 22'd919879;
        3: t = 22'd466945;   4: t = 22'd234379;   5: t = 22'd117304;
        6: t = 22'd58666;    7: t = 22'd29335;    8: t = 22'd14668;
        9: t = 22'd7334;     10: t = 22'd3667;    11: t = 22'd1833;
        12: t = 22'd917;     13: t = 22'd458;     14: t = 22'd229;
        15: t = 22'd115;     16: t = 22'd57;      17: t = 22'd29;
        18: t = 22'd14;      19: t = 22'd7;       20: t = 22'd4;
        21: t = 22'd2;       22: t = 22'd1;       default: t = 22'd0;
      endcase
      return t;
    end
  endfunction

endpackage
`default_nettype wire

FILE: design/vad_isqrt.sv
// Pipelined floor integer square root, two result bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module vad_isqrt #(
  parameter int IN_BITS = 64,
  parameter int TAG_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [IN_BITS-1:0]    radicand,
  input  wire logic [TAG_BITS-1:0]   in_tag,
  output logic                       out_valid,
  output logic [IN_BITS/2-1:0]       root,
  output logic [TAG_BITS-1:0]        out_tag
);
  localparam int HALF = IN_BITS / 2;
  localparam int STEPS = HALF;
  localparam int PER = 2;
  localparam int NST = (STEPS + PER - 1) / PER;

  logic [NST:0]               vld;
  logic [IN_BITS-1:0]         rem [NST+1];
  logic [HALF-1:0]            res [NST+1];
  logic [TAG_BITS-1:0]        tag [NST+1];

  assign vld[0] = in_valid;
  assign rem[0] = radicand;
  assign res[0] = '0;
  assign tag[0] = in_tag;

  // Each stage resolves PER root bits by restoring trial subtraction.
  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [IN_BITS-1:0] r_n;
    logic [HALF-1:0]    q_n;
    always_comb begin
      logic [IN_BITS+1:0] trial;
      r_n = rem[s];
      q_n = res[s];
      for (int k = 0; k < PER; k++) begin
        if (s * PER + k < STEPS) begin
          trial = ({2'b00, (IN_BITS)'(q_n)} << (2 * (STEPS - 1 - (s * PER + k)) + 2))
                | ((IN_BITS + 2)'(1) << (2 * (STEPS - 1 - (s * PER + k))));
          if ({2'b00, r_n} >= trial) begin
            r_n = r_n - IN_BITS'(trial);
            q_n = {q_n[HALF-2:0], 1'b1};
          end else begin
            q_n = {q_n[HALF-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vld[s+1] <= 1'b0;
      else vld[s+1] <= vld[s];
      rem[s+1] <= r_n;
      res[s+1] <= q_n;
      tag[s+1] <= tag[s];
    end
  end

  assign out_valid = vld[NST];
  assign root = res[NST];
  assign out_tag = tag[NST];
endmodule
`default_nettype wire

FILE: design/vector_angle_degrees.sv
// Angle between two 3D vectors, pipelined, with match and right-angle rules.
// Stage order: magnitude, shift, squares, sum, norm root, divide, unit, match, cosine,
// sine square, sine root, the CORDIC stages and final rounding, as the stage chain below sets.
// Throughput: one item per cycle; busy is never asserted.
// Reset clears all valid bits and both registers; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module vector_angle_degrees #(
  parameter int COMPONENT_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [COMPONENT_BITS-1:0]  a_x,
  input  wire logic signed [COMPONENT_BITS-1:0]  a_y,
  input  wire logic signed [COMPONENT_BITS-1:0]  a_z,
  input  wire logic signed [COMPONENT_BITS-1:0]  b_x,
  input  wire logic signed [COMPONENT_BITS-1:0]  b_y,
  input  wire logic signed [COMPONENT_BITS-1:0]  b_z,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [0:0]                        cfg_index,
  input  wire logic [7:0]                        cfg_data,
  output logic                                   done,
  output logic [15:0]                            angle_deg,
  output logic [1:0]                             case_code
);
  localparam int CB = COMPONENT_BITS;
  localparam int SB = 32;      // normalized magnitude width
  localparam int QB = 48;      // dividend width: mag << 15 plus rounding
  localparam int CS = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  logic [7:0] match_tol, right_band;
  always_ff @(posedge clk) begin
    if (rst) begin
      match_tol <= '0;
      right_band <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        vad_pkg::REG_MATCH_TOL:  match_tol <= cfg_data;
        vad_pkg::REG_RIGHT_BAND: right_band <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: magnitudes and signs per component (6 lanes).
  logic              v1;
  logic [CB:0]       mag1 [6];
  logic [5:0]        sgn1;
  logic signed [CB-1:0] comp [6];
  assign comp[0] = a_x; assign comp[1] = a_y; assign comp[2] = a_z;
  assign comp[3] = b_x; assign comp[4] = b_y; assign comp[5] = b_z;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    for (int i = 0; i < 6; i++) begin
      sgn1[i] <= comp[i][CB-1];
      mag1[i] <= comp[i][CB-1] ? (CB+1)'(-$signed({comp[i][CB-1], comp[i]}))
                               : (CB+1)'({comp[i][CB-1], comp[i]});
    end
  end

  // Stage 2: shift so the largest magnitude lands in [2^30, 2^31).
  logic           v2;
  logic [SB-1:0]  mag2 [6];
  logic [5:0]     sgn2;
  logic [1:0]     zero2;
  always_ff @(posedge clk) begin
    logic [CB:0] m;
    logic [5:0]  sh;
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    sgn2 <= sgn1;
    for (int v = 0; v < 2; v++) begin
      m = mag1[3*v] | mag1[3*v+1] | mag1[3*v+2];
      sh = 6'd0;
      for (int b = 0; b <= CB; b++) if (m[b]) sh = (b < 30) ? 6'(30 - b) : 6'd0;
      zero2[v] <= (m == '0);
      for (int k = 0; k < 3; k++)
        mag2[3*v+k] <= SB'({{(SB > CB+1 ? SB-CB-1 : 0){1'b0}}, mag1[3*v+k]} << sh);
    end
  end

  // Stage 3: squares. Stage 4: sum of squares.
  logic           v3, v4;
  logic [63:0]    sq3 [6];
  logic [SB-1:0]  mag3 [6], mag4 [6];
  logic [5:0]     sgn3, sgn4;
  logic [1:0]     zero3, zero4;
  logic [63:0]    sum4 [2];
  always_ff @(posedge clk) begin
    if (rst) begin v3 <= 1'b0; v4 <= 1'b0; end
    else begin v3 <= v2; v4 <= v3; end
    for (int i = 0; i < 6; i++) begin
      sq3[i] <= 64'(mag2[i]) * 64'(mag2[i]);
      mag3[i] <= mag2[i];
      mag4[i] <= mag3[i];
    end
    sgn3 <= sgn2; sgn4 <= sgn3; zero3 <= zero2; zero4 <= zero3;
    for (int v = 0; v < 2; v++) sum4[v] <= sq3[3*v] + sq3[3*v+1] + sq3[3*v+2];
  end

  // Norm square roots; side data rides along as a tag, the zero flags with the second root.
  localparam int T1 = 6*SB + 6;
  logic [T1-1:0] t4, ta;
  logic [1:0]    tb;
  logic          va, vb;
  logic [31:0]   norm_a, norm_b;
  always_comb begin
    for (int i = 0; i < 6; i++) t4[i*SB +: SB] = mag4[i];
    t4[6*SB +: 6] = sgn4;
  end
  vad_isqrt #(.IN_BITS(64), .TAG_BITS(T1)) u_sqa (
    .clk, .rst, .in_valid(v4), .radicand(sum4[0]), .in_tag(t4),
    .out_valid(va), .root(norm_a), .out_tag(ta));
  vad_isqrt #(.IN_BITS(64), .TAG_BITS(2)) u_sqb (
    .clk, .rst, .in_valid(v4), .radicand(sum4[1]), .in_tag(zero4),
    .out_valid(vb), .root(norm_b), .out_tag(tb));

  // Division pipeline: six restoring dividers, one quotient bit per stage.
  localparam int QN = 17;  // quotient bits: value is at most 2^16
  logic [QN:0]    dv;
  logic [QB-1:0]  drem [QN+1][6];
  logic [QN-1:0]  dq   [QN+1][6];
  logic [31:0]    dden [QN+1][2];
  logic [5:0]     dsg  [QN+1];
  logic [1:0]     dz   [QN+1];
  always_comb begin
    dv[0] = va;
    dden[0][0] = norm_a;
    dden[0][1] = norm_b;
    dsg[0] = ta[6*SB +: 6];
    dz[0] = tb;
    for (int i = 0; i < 6; i++) begin
      drem[0][i] = (QB'(ta[i*SB +: SB]) << 15) + QB'(((i < 3) ? norm_a : norm_b) >> 1);
      dq[0][i] = '0;
    end
  end
  for (genvar s = 0; s < QN; s++) begin : g_div
    always_ff @(posedge clk) begin
      logic [QB:0] tr;
      if (rst) dv[s+1] <= 1'b0;
      else dv[s+1] <= dv[s];
      dden[s+1] <= dden[s];
      dsg[s+1] <= dsg[s];
      dz[s+1] <= dz[s];
      for (int i = 0; i < 6; i++) begin
        tr = (QB+1)'(dden[s][i/3]) << (QN-1-s);
        if ({1'b0, drem[s][i]} >= tr) begin
          drem[s+1][i] <= drem[s][i] - QB'(tr);
          dq[s+1][i] <= dq[s][i] | (QN'(1) << (QN-1-s));
        end else begin
          drem[s+1][i] <= drem[s][i];
          dq[s+1][i] <= dq[s][i];
        end
      end
    end
  end

  // Unit components: saturate, apply sign, zero vectors stay zero.
  logic              vu;
  logic signed [16:0] u [6];
  always_ff @(posedge clk) begin
    logic [15:0] q;
    if (rst) vu <= 1'b0;
    else vu <= dv[QN];
    for (int i = 0; i < 6; i++) begin
      q = (dq[QN][i] > QN'(32767)) ? 16'd32767 : 16'(dq[QN][i]);
      if (dz[QN][i/3]) q = '0;
      u[i] <= dsg[QN][i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    end
  end

  // Match tests and products.
  logic               vm;
  logic               same_m, opp_m;
  logic signed [33:0] prod [3];
  always_ff @(posedge clk) begin
    logic signed [17:0] d, e;
    logic sm, op;
    if (rst) vm <= 1'b0;
    else vm <= vu;
    sm = 1'b1; op = 1'b1;
    for (int i = 0; i < 3; i++) begin
      d = 18'(u[i]) - 18'(u[i+3]);
      e = 18'(u[i]) + 18'(u[i+3]);
      if ((d < 0 ? -d : d) > $signed({10'd0, match_tol})) sm = 1'b0;
      if ((e < 0 ? -e : e) > $signed({10'd0, match_tol})) op = 1'b0;
      prod[i] <= 34'(u[i]) * 34'(u[i+3]);
    end
    same_m <= sm;
    opp_m <= op;
  end

  // Cosine: sum, round half away from zero, clamp, classify.
  logic               vc;
  logic [1:0]         code_c;
  logic               neg_c;
  logic [15:0]        ac_c;
  always_ff @(posedge clk) begin
    logic signed [35:0] dot;
    logic [35:0] ad;
    logic [20:0] c;
    if (rst) vc <= 1'b0;
    else vc <= vm;
    dot = 36'(prod[0]) + 36'(prod[1]) + 36'(prod[2]);
    ad = dot[35] ? 36'(-dot) : 36'(dot);
    c = 21'((ad + 36'd16384) >> 15);
    if (c > 21'(vad_pkg::COS_ONE)) c = 21'(vad_pkg::COS_CLAMP);
    neg_c <= dot[35] && (c != '0);
    ac_c <= 16'(c > 21'd32768 ? 21'd32768 : c);
    if (same_m) code_c <= vad_pkg::CASE_SAME;
    else if (opp_m) code_c <= vad_pkg::CASE_OPPOSITE;
    else if (!dot[35] && c != '0 && c < 21'(right_band)) code_c <= vad_pkg::CASE_RIGHT;
    else code_c <= vad_pkg::CASE_GENERAL;
  end

  // Sine term: square, then root of 2^30 - c^2.
  logic        vs;
  logic [31:0] one_m;
  logic [1:0]  code_s;
  logic        neg_s;
  logic [15:0] ac_s;
  always_ff @(posedge clk) begin
    if (rst) vs <= 1'b0;
    else vs <= vc;
    one_m <= 32'(33'h40000000 - 33'(32'(ac_c) * 32'(ac_c)));
    code_s <= code_c; neg_s <= neg_c; ac_s <= ac_c;
  end
  logic        vr;
  logic [15:0] sroot;
  logic [18:0] tr_o;
  vad_isqrt #(.IN_BITS(32), .TAG_BITS(19)) u_sqs (
    .clk, .rst, .in_valid(vs), .radicand(one_m), .in_tag({code_s, neg_s, ac_s}),
    .out_valid(vr), .root(sroot), .out_tag(tr_o));

  // CORDIC vectoring stages.
  logic               cv [CS+1];
  logic signed [33:0] cx [CS+1], cy [CS+1];
  logic signed [25:0] cz [CS+1];
  logic [18:0]        ct [CS+1];
  assign cv[0] = vr;
  assign cx[0] = 34'(ct[0][15:0]) <<< vad_pkg::CORDIC_PREC;
  assign cy[0] = 34'(sroot) <<< vad_pkg::CORDIC_PREC;
  assign cz[0] = '0;
  assign ct[0] = tr_o;
  for (genvar s = 0; s < CS; s++) begin : g_cor
    logic signed [33:0] dx, dy;
    always_comb begin
      dx = cy[s][33] ? -((-cy[s]) >>> s) : (cy[s] >>> s);
      dy = cx[s][33] ? -((-cx[s]) >>> s) : (cx[s] >>> s);
    end
    always_ff @(posedge clk) begin
      if (rst) cv[s+1] <= 1'b0;
      else cv[s+1] <= cv[s];
      ct[s+1] <= ct[s];
      if (!cy[s][33]) begin
        cx[s+1] <= cx[s] + dx;
        cy[s+1] <= cy[s] - dy;
        cz[s+1] <= cz[s] + $signed({4'd0, vad_pkg::atan_deg(s)});
      end else begin
        cx[s+1] <= cx[s] - dx;
        cy[s+1] <= cy[s] + dy;
        cz[s+1] <= cz[s] - $signed({4'd0, vad_pkg::atan_deg(s)});
      end
    end
  end

  // Final: reflect, round to Q8.8, clamp, select by case.
  always_ff @(posedge clk) begin
    logic signed [25:0] z;
    logic signed [25:0] r;
    if (rst) done <= 1'b0;
    else done <= cv[CS];
    z = ct[CS][16] ? 26'(vad_pkg::DEG180_Q16) - cz[CS] : cz[CS];
    if (z < 0) z = '0;
    r = (z + 26'sd128) >>> 8;
    if (r > 26'(vad_pkg::DEG180_Q8)) r = 26'(vad_pkg::DEG180_Q8);
    case_code <= ct[CS][18:17];
    case (ct[CS][18:17])
      vad_pkg::CASE_SAME:     angle_deg <= '0;
      vad_pkg::CASE_OPPOSITE: angle_deg <= 16'(vad_pkg::DEG180_Q8);
      vad_pkg::CASE_RIGHT:    angle_deg <= 16'(vad_pkg::DEG90_Q8);
      default:                angle_deg <= r[15:0];
    endcase
  end

`ifndef NO_ASSERTIONS
  a_busy_low: assert property (@(posedge clk) !busy) else $error("busy asserted");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done |-> angle_deg <= 16'(vad_pkg::DEG180_Q8)) else $error("angle above 180");
  a_same_zero: assert property (@(posedge clk) disable iff (rst)
    done && case_code == vad_pkg::CASE_SAME |-> angle_deg == '0) else $error("same not 0");
  a_roots_aligned: assert property (@(posedge clk) disable iff (rst)
    va == vb) else $error("norm roots out of step");
`endif
endmodule
`default_nettype wire
